>>> rtl/core/lavm_pkg.sv
package lavm_pkg;

    localparam int UNIT_W = 18;

    localparam logic [1:0] CFG_UP_X = 2'd0;
    localparam logic [1:0] CFG_UP_Y = 2'd1;
    localparam logic [1:0] CFG_UP_Z = 2'd2;

    typedef logic signed [UNIT_W-1:0] t_unit;

endpackage

>>> rtl/core/look_at_view_matrix_top.sv
// Channel   Direction  Handshake               Payload
// input     in         i_valid / o_stall       i_eye_*, i_target_* (Q16.16)
// output    out        o_valid / i_stall       o_row0_* .. o_row2_* (Q1.16), o_shift_* (Q16.16)
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One transaction is accepted per cycle while the output is not stalled. Each of
// the two normalizers holds a 32-stage square root and a 17-stage divider.
// Reset is synchronous and clears only the valid bits and the configuration. A stall
// on a valid output freezes the whole pipeline and is passed back to the input in
// the same cycle, so no transaction is lost or repeated.
module look_at_view_matrix_top
    import lavm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_eye_x,
    input  logic [31:0] i_eye_y,
    input  logic [31:0] i_eye_z,
    input  logic [31:0] i_target_x,
    input  logic [31:0] i_target_y,
    input  logic [31:0] i_target_z,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [17:0] o_row0_x,
    output logic [17:0] o_row0_y,
    output logic [17:0] o_row0_z,
    output logic [17:0] o_row1_x,
    output logic [17:0] o_row1_y,
    output logic [17:0] o_row1_z,
    output logic [17:0] o_row2_x,
    output logic [17:0] o_row2_y,
    output logic [17:0] o_row2_z,
    output logic [31:0] o_shift_x,
    output logic [31:0] o_shift_y,
    output logic [31:0] o_shift_z,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam t_unit       ONE_Q16  = t_unit'(65536);
    localparam int          FW       = 33;
    localparam int          SVW      = 50;
    localparam int          EW       = 96;
    localparam int          T2W      = 1 + 3 * UNIT_W + EW;

    logic               w_adv;
    logic signed [31:0] r_up [3];
    logic signed [31:0] w_eye [3];
    logic signed [31:0] w_tgt [3];

    logic               r_a_vld;
    logic signed [FW-1:0] r_a_fw [3];
    logic [EW-1:0]      r_a_eye;

    logic               n1_vld;
    logic               n1_ok;
    t_unit              n1_f [3];
    logic [EW-1:0]      n1_tag;

    logic               r_b_vld;
    logic               r_b_ok;
    logic signed [49:0] r_b_p [6];
    t_unit              r_b_f [3];
    logic [EW-1:0]      r_b_eye;

    logic               r_c_vld;
    logic               r_c_ok;
    logic signed [SVW-1:0] r_c_sv [3];
    t_unit              r_c_f [3];
    logic [EW-1:0]      r_c_eye;

    logic               n2_vld;
    logic               n2_ok;
    t_unit              n2_s [3];
    logic [T2W-1:0]     n2_tag;

    logic               r_d_vld;
    logic               r_d_ok;
    logic signed [35:0] r_d_q [6];
    t_unit              r_d_s [3];
    t_unit              r_d_f [3];
    logic signed [31:0] r_d_eye [3];

    logic               r_e_vld;
    t_unit              r_e_rot [9];
    logic signed [FW-1:0] r_e_neye [3];

    logic               r_f_vld;
    logic signed [50:0] r_f_p [9];
    t_unit              r_f_rot [9];

    logic               r_g_vld;
    logic signed [51:0] r_g_acc [3];
    t_unit              r_g_rot [9];

    logic               r_h_vld;
    t_unit              r_h_rot [9];
    logic [31:0]        r_h_shift [3];

    t_unit              w_u [3];

    function automatic t_unit rnd_clamp(input logic signed [36:0] p);
        logic [36:0] m;
        logic [20:0] r;
        m = p[36] ? 37'(-p) : 37'(p);
        r = 21'((m + 37'd32768) >> 16);
        if (r > 21'd65536) begin
            r = 21'd65536;
        end
        return p[36] ? -t_unit'(r) : t_unit'(r);
    endfunction

    function automatic logic [31:0] rnd_sat(input logic signed [51:0] p);
        logic [51:0] m;
        logic [36:0] r;
        logic [31:0] v;
        m = p[51] ? 52'(-p) : 52'(p);
        r = 37'((m + 52'd32768) >> 16);
        if (p[51]) begin
            v = (r > 37'h0_8000_0000) ? 32'h8000_0000 : 32'(-r);
        end else begin
            v = (r > 37'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
        end
        return v;
    endfunction

    assign w_adv       = !(r_h_vld && i_stall);
    assign o_stall     = r_h_vld && i_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up[0] <= 32'sd0;
            r_up[1] <= 32'sd65536;
            r_up[2] <= 32'sd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_UP_X: r_up[0] <= i_cfg_data;
                CFG_UP_Y: r_up[1] <= i_cfg_data;
                CFG_UP_Z: r_up[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_eye[0] = i_eye_x;
    assign w_eye[1] = i_eye_y;
    assign w_eye[2] = i_eye_z;
    assign w_tgt[0] = i_target_x;
    assign w_tgt[1] = i_target_y;
    assign w_tgt[2] = i_target_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
        end else if (w_adv) begin
            r_a_vld <= i_valid;
            r_b_vld <= n1_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= n2_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
            r_h_vld <= r_g_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_a_fw[i] <= FW'(w_tgt[i]) - FW'(w_eye[i]);
            end
            r_a_eye <= {i_eye_z, i_eye_y, i_eye_x};
        end
    end

    lavm_norm #(
        .W  (FW),
        .TW (EW)
    ) u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r_a_vld),
        .i_vec   (r_a_fw),
        .i_tag   (r_a_eye),
        .o_vld   (n1_vld),
        .o_ok    (n1_ok),
        .o_unit  (n1_f),
        .o_tag   (n1_tag)
    );

    // Side vector: forward cross up hint.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_p[0] <= 50'(n1_f[1]) * 50'(r_up[2]);
            r_b_p[1] <= 50'(n1_f[2]) * 50'(r_up[1]);
            r_b_p[2] <= 50'(n1_f[2]) * 50'(r_up[0]);
            r_b_p[3] <= 50'(n1_f[0]) * 50'(r_up[2]);
            r_b_p[4] <= 50'(n1_f[0]) * 50'(r_up[1]);
            r_b_p[5] <= 50'(n1_f[1]) * 50'(r_up[0]);
            r_b_f    <= n1_f;
            r_b_ok   <= n1_ok;
            r_b_eye  <= n1_tag;

            r_c_sv[0] <= r_b_p[0] - r_b_p[1];
            r_c_sv[1] <= r_b_p[2] - r_b_p[3];
            r_c_sv[2] <= r_b_p[4] - r_b_p[5];
            r_c_f     <= r_b_f;
            r_c_ok    <= r_b_ok;
            r_c_eye   <= r_b_eye;
        end
    end

    lavm_norm #(
        .W  (SVW),
        .TW (T2W)
    ) u_norm_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r_c_vld),
        .i_vec   (r_c_sv),
        .i_tag   ({r_c_ok, r_c_f[2], r_c_f[1], r_c_f[0], r_c_eye}),
        .o_vld   (n2_vld),
        .o_ok    (n2_ok),
        .o_unit  (n2_s),
        .o_tag   (n2_tag)
    );

    // Recomputed up: side cross forward.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_d_f[i]   <= t_unit'(n2_tag[EW + UNIT_W * i +: UNIT_W]);
                r_d_eye[i] <= n2_tag[32 * i +: 32];
            end
            r_d_q[0] <= 36'(n2_s[1]) * 36'(t_unit'(n2_tag[EW + 2 * UNIT_W +: UNIT_W]));
            r_d_q[1] <= 36'(n2_s[2]) * 36'(t_unit'(n2_tag[EW + UNIT_W +: UNIT_W]));
            r_d_q[2] <= 36'(n2_s[2]) * 36'(t_unit'(n2_tag[EW +: UNIT_W]));
            r_d_q[3] <= 36'(n2_s[0]) * 36'(t_unit'(n2_tag[EW + 2 * UNIT_W +: UNIT_W]));
            r_d_q[4] <= 36'(n2_s[0]) * 36'(t_unit'(n2_tag[EW + UNIT_W +: UNIT_W]));
            r_d_q[5] <= 36'(n2_s[1]) * 36'(t_unit'(n2_tag[EW +: UNIT_W]));
            r_d_s    <= n2_s;
            r_d_ok   <= n2_ok && n2_tag[T2W-1];
        end
    end

    always_comb begin
        w_u[0] = rnd_clamp(37'(r_d_q[0]) - 37'(r_d_q[1]));
        w_u[1] = rnd_clamp(37'(r_d_q[2]) - 37'(r_d_q[3]));
        w_u[2] = rnd_clamp(37'(r_d_q[4]) - 37'(r_d_q[5]));
    end

    // A degenerate frame falls back to identity, so the shift becomes -eye.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int j = 0; j < 3; j++) begin
                if (r_d_ok) begin
                    r_e_rot[j]     <= r_d_s[j];
                    r_e_rot[3 + j] <= w_u[j];
                    r_e_rot[6 + j] <= -r_d_f[j];
                end else begin
                    r_e_rot[j]     <= (j == 0) ? ONE_Q16 : '0;
                    r_e_rot[3 + j] <= (j == 1) ? ONE_Q16 : '0;
                    r_e_rot[6 + j] <= (j == 2) ? ONE_Q16 : '0;
                end
                r_e_neye[j] <= -FW'(r_d_eye[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_f_p[3 * i + j] <= 51'(r_e_rot[3 * i + j]) * 51'(r_e_neye[j]);
                end
            end
            r_f_rot <= r_e_rot;

            for (int i = 0; i < 3; i++) begin
                r_g_acc[i] <= 52'(r_f_p[3 * i]) + 52'(r_f_p[3 * i + 1])
                            + 52'(r_f_p[3 * i + 2]);
            end
            r_g_rot <= r_f_rot;

            for (int i = 0; i < 3; i++) begin
                r_h_shift[i] <= rnd_sat(r_g_acc[i]);
            end
            r_h_rot <= r_g_rot;
        end
    end

    assign o_valid   = r_h_vld;
    assign o_row0_x  = r_h_rot[0];
    assign o_row0_y  = r_h_rot[1];
    assign o_row0_z  = r_h_rot[2];
    assign o_row1_x  = r_h_rot[3];
    assign o_row1_y  = r_h_rot[4];
    assign o_row1_z  = r_h_rot[5];
    assign o_row2_x  = r_h_rot[6];
    assign o_row2_y  = r_h_rot[7];
    assign o_row2_z  = r_h_rot[8];
    assign o_shift_x = r_h_shift[0];
    assign o_shift_y = r_h_shift[1];
    assign o_shift_z = r_h_shift[2];

endmodule

>>> rtl/core/lavm_norm.sv
module lavm_norm
    import lavm_pkg::*;
#(
    parameter int W  = 33,
    parameter int TW = 96
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic signed [W-1:0] i_vec [3],
    input  logic [TW-1:0]       i_tag,
    output logic                o_vld,
    output logic                o_ok,
    output t_unit               o_unit [3],
    output logic [TW-1:0]       o_tag
);

    localparam int SHN = 6;
    localparam int MW  = 30;
    localparam int SQW = 64;
    localparam int SQN = SQW / 2;
    localparam int QW  = UNIT_W - 1;
    localparam int LW  = SQW / 2;
    localparam int NW  = MW + QW + 1;
    localparam int DW  = LW + 1;
    localparam int SW  = TW + 4;

    logic [SHN:0]    r_sh_vld;
    logic [W-1:0]    r_sh_mg   [SHN+1][3];
    logic [SW-1:0]   r_sh_side [SHN+1];

    logic            r_sq_vld;
    logic [2*MW-1:0] r_sq      [3];
    logic [MW-1:0]   r_sq_t    [3];
    logic [SW-1:0]   r_sq_side;

    logic [SQN:0]    r_rt_vld;
    logic [SQW-1:0]  r_rt_n    [SQN+1];
    logic [SQW-1:0]  r_rt_res  [SQN+1];
    logic [MW-1:0]   r_rt_t    [SQN+1][3];
    logic [SW-1:0]   r_rt_side [SQN+1];

    logic [QW:0]     r_dv_vld;
    logic [NW-1:0]   r_dv_rem  [QW+1][3];
    logic [QW-1:0]   r_dv_q    [QW+1][3];
    logic [DW-1:0]   r_dv_d    [QW+1];
    logic [SW-1:0]   r_dv_side [QW+1];

    logic [MW-1:0]   w_t [3];
    logic [LW-1:0]   w_len;

    // Magnitudes and signs; the leading-one search works on their OR.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_sh_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sh_mg[0][i] <= i_vec[i][W-1] ? W'(-i_vec[i]) : W'(i_vec[i]);
            end
            r_sh_side[0] <= {(i_vec[0] != '0) || (i_vec[1] != '0) || (i_vec[2] != '0),
                             i_vec[2][W-1], i_vec[1][W-1], i_vec[0][W-1], i_tag};
        end
    end

    for (genvar g = 0; g < SHN; g++) begin : g_shift
        localparam int K = 1 << (SHN - 1 - g);
        logic [W-1:0] lead;
        logic         hit;

        assign lead = r_sh_mg[g][0] | r_sh_mg[g][1] | r_sh_mg[g][2];
        assign hit  = (lead[W-1 -: K] == '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sh_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_sh_vld[g+1] <= r_sh_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    r_sh_mg[g+1][i] <= hit ? (r_sh_mg[g][i] << K) : r_sh_mg[g][i];
                end
                r_sh_side[g+1] <= r_sh_side[g];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_t[i] = r_sh_mg[SHN][i][W-1 -: MW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld    <= 1'b0;
            r_rt_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_sq_vld    <= r_sh_vld[SHN];
            r_rt_vld[0] <= r_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i]   <= (2*MW)'(w_t[i]) * (2*MW)'(w_t[i]);
                r_sq_t[i] <= w_t[i];
            end
            r_sq_side    <= r_sh_side[SHN];
            r_rt_n[0]    <= SQW'(r_sq[0]) + SQW'(r_sq[1]) + SQW'(r_sq[2]);
            r_rt_res[0]  <= '0;
            r_rt_t[0]    <= r_sq_t;
            r_rt_side[0] <= r_sq_side;
        end
    end

    // Integer square root, one result bit per stage.
    for (genvar j = 0; j < SQN; j++) begin : g_sqrt
        localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 - 2 * j);
        logic [SQW-1:0] trial;

        assign trial = r_rt_res[j] + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt_vld[j+1] <= 1'b0;
            end else if (i_en) begin
                r_rt_vld[j+1] <= r_rt_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_rt_n[j] >= trial) begin
                    r_rt_n[j+1]   <= r_rt_n[j] - trial;
                    r_rt_res[j+1] <= (r_rt_res[j] >> 1) + BIT;
                end else begin
                    r_rt_n[j+1]   <= r_rt_n[j];
                    r_rt_res[j+1] <= r_rt_res[j] >> 1;
                end
                r_rt_t[j+1]    <= r_rt_t[j];
                r_rt_side[j+1] <= r_rt_side[j];
            end
        end
    end

    assign w_len = r_rt_res[SQN][LW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_dv_vld[0] <= r_rt_vld[SQN];
        end
    end

    // Rounded quotient: (t * 2^17 + len) / (2 * len).
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[0][i] <= (NW'(r_rt_t[SQN][i]) << QW) + NW'(w_len);
                r_dv_q[0][i]   <= '0;
            end
            r_dv_d[0]    <= {w_len, 1'b0};
            r_dv_side[0] <= r_rt_side[SQN];
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int K = QW - 1 - j;
        logic [NW+1:0] dk;

        assign dk = (NW+2)'(r_dv_d[j]) << K;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j+1] <= 1'b0;
            end else if (i_en) begin
                r_dv_vld[j+1] <= r_dv_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    if ((NW+2)'(r_dv_rem[j][i]) >= dk) begin
                        r_dv_rem[j+1][i] <= NW'((NW+2)'(r_dv_rem[j][i]) - dk);
                        r_dv_q[j+1][i]   <= r_dv_q[j][i] | (QW'(1) << K);
                    end else begin
                        r_dv_rem[j+1][i] <= r_dv_rem[j][i];
                        r_dv_q[j+1][i]   <= r_dv_q[j][i];
                    end
                end
                r_dv_d[j+1]    <= r_dv_d[j];
                r_dv_side[j+1] <= r_dv_side[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= r_dv_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                o_unit[i] <= r_dv_side[QW][TW+i] ? -t_unit'(r_dv_q[QW][i])
                                                 : t_unit'(r_dv_q[QW][i]);
            end
            o_ok  <= r_dv_side[QW][TW+3];
            o_tag <= r_dv_side[QW][TW-1:0];
        end
    end

endmodule

>>> dv/look_at_view_matrix_top_tb.sv
module look_at_view_matrix_top_tb
    import lavm_pkg::*;
();

    localparam int LATENCY = 128;
    localparam int IDLE_LIMIT = 20000;
    localparam int N_RANDOM = 750;
    localparam logic [1:0] REG_NONE = 2'd3;
    localparam logic signed [31:0] ONE = 32'sd65536;
    localparam t_unit ONE_U = t_unit'(65536);
    localparam logic signed [31:0] SMAX = 32'sh7fffffff;
    localparam logic signed [31:0] SMIN = 32'sh80000000;

    typedef struct {
        logic signed [31:0] eye [3];
        logic signed [31:0] tgt [3];
    } t_view_in;

    typedef struct {
        t_unit rot [9];
        logic signed [31:0] shift [3];
    } t_view_out;

    typedef struct {
        t_view_in v;
        bit has_exp;
        t_view_out e;
    } t_row;

    logic i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall;
    logic [31:0] i_eye_x, i_eye_y, i_eye_z, i_target_x, i_target_y, i_target_z;
    logic [17:0] o_row0_x, o_row0_y, o_row0_z, o_row1_x, o_row1_y, o_row1_z;
    logic [17:0] o_row2_x, o_row2_y, o_row2_z;
    logic [31:0] o_shift_x, o_shift_y, o_shift_z;
    logic i_cfg_valid, o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    look_at_view_matrix_top dut (.*);

    logic signed [31:0] up_hint [3];
    t_view_out expected_views [$];
    int n_errors = 0;
    int idle_cycles = 0;
    bit hold_req = 0;
    bit hold_off = 0;
    bit stim_done = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] mag(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit to_unit(input logic signed [63:0] v [3],
                                   output logic signed [63:0] u [3]);
        logic [63:0] m, mg [3], sum, len, q;
        int nb;
        m = 0;
        sum = 0;
        nb = 0;
        for (int i = 0; i < 3; i++) begin
            mg[i] = mag(v[i]);
            if (mg[i] > m) m = mg[i];
        end
        if (m == 0) return 0;
        while (nb < 63 && (m >> nb) != 0) nb++;
        for (int i = 0; i < 3; i++) begin
            if (nb > 30) mg[i] >>= (nb - 30);
            else mg[i] <<= (30 - nb);
            sum += mg[i] * mg[i];
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((mg[i] << 17) + len) / (2 * len);
            u[i] = v[i] < 0 ? -$signed(q) : $signed(q);
        end
        return 1;
    endfunction

    function automatic logic signed [63:0] round_q16(input logic signed [63:0] p);
        logic [63:0] r;
        r = (mag(p) + 64'd32768) >> 16;
        return p < 0 ? -$signed(r) : $signed(r);
    endfunction

    function automatic t_view_out look_at(input t_view_in v);
        logic signed [63:0] fw [3], f [3], sv [3], s [3], u [3], up [3], rot [3][3];
        logic signed [63:0] acc, t;
        bit ok;
        t_view_out r;
        for (int i = 0; i < 3; i++) begin
            fw[i] = 64'(v.tgt[i]) - 64'(v.eye[i]);
            up[i] = 64'(up_hint[i]);
        end
        ok = to_unit(fw, f);
        if (ok) begin
            sv[0] = f[1] * up[2] - f[2] * up[1];
            sv[1] = f[2] * up[0] - f[0] * up[2];
            sv[2] = f[0] * up[1] - f[1] * up[0];
            ok = to_unit(sv, s);
        end
        if (ok) begin
            u[0] = round_q16(s[1] * f[2] - s[2] * f[1]);
            u[1] = round_q16(s[2] * f[0] - s[0] * f[2]);
            u[2] = round_q16(s[0] * f[1] - s[1] * f[0]);
            for (int i = 0; i < 3; i++) begin
                if (u[i] > ONE) u[i] = ONE;
                if (u[i] < -ONE) u[i] = -ONE;
                rot[0][i] = s[i];
                rot[1][i] = u[i];
                rot[2][i] = -f[i];
            end
        end else begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    rot[i][j] = (i == j) ? 64'(ONE) : 64'sd0;
        end
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) begin
                r.rot[i * 3 + j] = t_unit'(rot[i][j]);
                acc += rot[i][j] * (-64'(v.eye[j]));
            end
            t = round_q16(acc);
            if (t > SMAX) t = SMAX;
            if (t < SMIN) t = SMIN;
            r.shift[i] = t[31:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h", what, got, want);
        n_errors++;
    endtask

    task automatic check_view(input t_view_out g, input t_view_out e);
        for (int k = 0; k < 9; k++)
            if (g.rot[k] !== e.rot[k])
                report_mismatch($sformatf("row%0d_%0d", k / 3, k % 3),
                                32'(g.rot[k]), 32'(e.rot[k]));
        for (int k = 0; k < 3; k++)
            if (g.shift[k] !== e.shift[k])
                report_mismatch($sformatf("shift_%0d", k), g.shift[k], e.shift[k]);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx != REG_NONE) up_hint[idx] = val;
    endtask

    task automatic send_view(input t_view_in v);
        i_valid <= 1;
        {i_eye_x, i_eye_y, i_eye_z} <= {v.eye[0], v.eye[1], v.eye[2]};
        {i_target_x, i_target_y, i_target_z} <= {v.tgt[0], v.tgt[1], v.tgt[2]};
        do @(posedge i_clk); while (o_stall);
        expected_views.push_back(look_at(v));
    endtask

    task automatic sender_gap();
        if ($urandom_range(0, 7) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        while (expected_views.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    function automatic t_view_in rand_view(input int mode);
        t_view_in v;
        for (int i = 0; i < 3; i++) begin
            v.eye[i] = $urandom;
            case (mode)
                0: v.tgt[i] = $urandom;
                1: v.tgt[i] = v.eye[i] + $signed($urandom_range(0, 8191)) - 4096;
                default: begin
                    v.eye[i] = $signed($urandom_range(0, 2097151)) - 1048576;
                    v.tgt[i] = $signed($urandom_range(0, 2097151)) - 1048576;
                end
            endcase
        end
        if ($urandom_range(0, 40) == 0) v.tgt = v.eye;
        return v;
    endfunction

    function automatic t_view_in mk(input logic [31:0] ex, ey, ez, tx, ty, tz);
        t_view_in v;
        v.eye = '{ex, ey, ez};
        v.tgt = '{tx, ty, tz};
        return v;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) i_stall <= hold_off;
        else i_stall <= ($urandom_range(0, 3) == 0) && ($urandom_range(0, 1) == 0);
    end

    always @(posedge i_clk) begin
        t_view_out e, g;
        if (i_rst_n && o_valid && !i_stall) begin
            g.rot = '{o_row0_x, o_row0_y, o_row0_z, o_row1_x, o_row1_y, o_row1_z,
                      o_row2_x, o_row2_y, o_row2_z};
            g.shift = '{o_shift_x, o_shift_y, o_shift_z};
            if (expected_views.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                e = expected_views.pop_front();
                check_view(g, e);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)
                || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        t_row dir [$];
        t_row r;
        t_view_out id_out;
        logic signed [31:0] cfgs [5][3];
        i_rst_n = 0;
        i_valid = 0;
        i_stall = 0;
        i_cfg_valid = 0;
        i_cfg_index = 0;
        i_cfg_data = 0;
        {i_eye_x, i_eye_y, i_eye_z, i_target_x, i_target_y, i_target_z} = '0;
        up_hint = '{0, ONE, 0};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        id_out.rot = '{ONE_U, '0, '0, '0, ONE_U, '0, '0, '0, ONE_U};
        r.has_exp = 1;
        r.v = mk(0, 0, 0, 0, 0, 0);
        id_out.shift = '{0, 0, 0};
        r.e = id_out;
        dir.push_back(r);
        r.v = mk(SMIN, SMIN, SMIN, SMIN, SMIN, SMIN);
        id_out.shift = '{SMAX, SMAX, SMAX};
        r.e = id_out;
        dir.push_back(r);
        r.v = mk(SMAX, 5, SMIN + 1, SMAX, 5, SMIN + 1);
        id_out.shift = '{SMIN + 1, -5, SMAX};
        r.e = id_out;
        dir.push_back(r);
        r.v = mk(0, 0, 0, 0, ONE, 0);
        id_out.shift = '{0, 0, 0};
        r.e = id_out;
        dir.push_back(r);
        r.v = mk(0, 0, 0, 0, 0, -ONE);
        r.e.rot = '{ONE_U, '0, '0, '0, ONE_U, '0, '0, '0, ONE_U};
        r.e.shift = '{0, 0, 0};
        dir.push_back(r);
        r.has_exp = 0;
        r.v = mk(SMIN, SMIN, SMIN, SMAX, SMAX, SMAX);
        dir.push_back(r);
        r.v = mk(SMAX, SMAX, SMAX, SMIN, SMIN, SMIN);
        dir.push_back(r);
        r.v = mk(SMAX, SMIN, SMAX, SMIN, SMAX, SMIN);
        dir.push_back(r);
        r.v = mk(ONE, 2 * ONE, 3 * ONE, 0, 0, 0);
        dir.push_back(r);
        r.v = mk(0, 0, 0, 1, 0, 0);
        dir.push_back(r);
        r.v = mk(-7, 3, 11, 100 * ONE, -ONE, 1);
        dir.push_back(r);
        r.v = mk(SMIN, 0, SMAX, SMAX, -1, SMIN);
        dir.push_back(r);
        r.v = mk(-1, -1, -1, 0, 0, 0);
        dir.push_back(r);

        foreach (dir[k]) begin
            if (dir[k].has_exp) check_view(look_at(dir[k].v), dir[k].e);
            send_view(dir[k].v);
            sender_gap();
        end
        i_valid <= 0;
        drain();

        cfgs = '{'{ONE, 0, 0}, '{SMAX, SMAX, SMIN}, '{0, 0, 0}, '{1, -1, 1},
                 '{SMIN, 3, SMAX}};
        for (int c = 0; c < 6; c++) begin
            if (c < 5) begin
                write_reg(CFG_UP_X, cfgs[c][0]);
                write_reg(CFG_UP_Y, cfgs[c][1]);
                write_reg(CFG_UP_Z, cfgs[c][2]);
            end else begin
                write_reg(CFG_UP_X, $urandom);
                write_reg(CFG_UP_Y, $urandom);
                write_reg(CFG_UP_Z, $urandom);
                write_reg(REG_NONE, $urandom);
            end
            i_cfg_valid <= 0;
            if (c == 2) begin
                send_view(mk(0, 0, 0, ONE, 0, 0));
            end
            for (int n = 0; n < N_RANDOM / 6; n++) begin
                if (c == 1 && n == 20) hold_req = 1;
                send_view(rand_view($urandom_range(0, 2)));
                if (!hold_off) sender_gap();
            end
            i_valid <= 0;
            drain();
        end

        stim_done = 1;
        if (n_errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        wait (hold_req);
        hold_off = 1;
        repeat (300) @(posedge i_clk);
        hold_off = 0;
    end

endmodule
